@@ sv/sector_cache_lfu_controller_defines.svh @@
// Assertion macros shared by the controller modules.
// The using module must have clk and rst_n in scope.
`ifndef SECTOR_CACHE_LFU_CONTROLLER_DEFINES_SVH
`define SECTOR_CACHE_LFU_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SCL_ASSERT(lbl, prop, msg)
`define SCL_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ sv/sclfu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sclfu_pkg;

  localparam int ENTRIES     = 1024;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int SECTOR_W    = 28;
  localparam int SLOT_W      = 10;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [IDX_W:0]         fcnt_t;
  typedef logic [SECTOR_W-1:0]    sector_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SLOT_W-1:0]      slot_t;

  localparam fcnt_t FCNT_FULL = fcnt_t'(ENTRIES);

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    sector_t tag;
    count_t  count;
  } entry_t;

  // Summary of one lookup pass, valid in the cycle where done is high.
  typedef struct packed {
    logic    done;
    logic    hit;
    idx_t    hit_idx;
    count_t  hit_count;
    idx_t    min_idx;
    sector_t min_tag;
  } scan_stat_t;

endpackage

`default_nettype wire

@@ sv/sclfu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sclfu_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 44,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/sclfu_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "sector_cache_lfu_controller_defines.svh"

module sclfu_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  sclfu_pkg::sector_t   sector,
  input  sclfu_pkg::fcnt_t     limit,
  input  sclfu_pkg::entry_t    rd_data,
  output logic                 rd_en,
  output sclfu_pkg::idx_t      rd_addr,
  output sclfu_pkg::scan_stat_t stat
);
  import sclfu_pkg::*;

  logic   active_r;
  fcnt_t  issue_r;
  logic   pend_r;
  idx_t   pend_idx_r;
  logic   found_r;
  idx_t   hit_idx_r;
  count_t hit_count_r;
  idx_t   min_idx_r;
  count_t min_count_r;
  sector_t min_tag_r;

  logic more;
  logic match;
  logic take_min;
  logic fin;

  // Reads are issued one per cycle; the data of each comes back in the next cycle.
  assign more     = active_r && !found_r && (issue_r < limit);
  assign rd_en    = more;
  assign rd_addr  = issue_r[IDX_W-1:0];
  assign match    = pend_r && !found_r && (rd_data.tag == sector);
  // Strict less-than keeps the lowest index among equal counts.
  assign take_min = pend_r && ((pend_idx_r == '0) || (rd_data.count < min_count_r));
  assign fin      = active_r && !pend_r && (found_r || (issue_r == limit));

  always_ff @(posedge clk) begin
    pend_idx_r <= rd_addr;
    if (match) begin
      hit_idx_r   <= pend_idx_r;
      hit_count_r <= rd_data.count;
    end
    if (take_min) begin
      min_idx_r   <= pend_idx_r;
      min_count_r <= rd_data.count;
      min_tag_r   <= rd_data.tag;
    end
    if (!rst_n) begin
      active_r <= 1'b0;
      issue_r  <= '0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
    end else if (start) begin
      active_r <= 1'b1;
      issue_r  <= '0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      pend_r <= more;
      if (more) begin
        issue_r <= issue_r + fcnt_t'(1);
      end
      if (match) begin
        found_r <= 1'b1;
      end
      if (fin) begin
        active_r <= 1'b0;
      end
    end
  end

  assign stat.done      = fin;
  assign stat.hit       = found_r;
  assign stat.hit_idx   = hit_idx_r;
  assign stat.hit_count = hit_count_r;
  assign stat.min_idx   = min_idx_r;
  assign stat.min_tag   = min_tag_r;

  `SCL_ASSERT(a_rd_in_range, (!rd_en || ({1'b0, rd_addr} < limit)), "read beyond filled entries")
  `SCL_ASSERT_NEXT(a_done_pulse, stat.done, !stat.done, "done held for more than one cycle")
  `SCL_ASSERT(a_hit_in_range, (!found_r || ({1'b0, hit_idx_r} < limit)), "hit outside filled entries")

endmodule

`default_nettype wire

@@ sv/sector_cache_lfu_controller.sv @@
// Tag and least-frequently-used replacement controller of a fully associative
// sector cache. A request (in_func, in_sector_number) is taken on the in_valid /
// in_ready transaction; one result per request leaves on the out_valid /
// out_ready transaction. cfg_we writes cfg_wdata into the cache enable bit.
// Tags and use counts live in one single-port-read memory. Entries are filled
// in index order, so a fill counter marks which entries are valid.
// With the cache disabled a result goes to the done state without a lookup pass.
// With the cache enabled one lookup pass reads the filled entries one per
// cycle, matching the tag and tracking the least-used entry at the same time;
// a hit stops the pass early. One request is worked on at a time, and
// in_ready is high only while the controller waits for a request.
// Reset empties the cache (fill counter to zero) and disables it; no clearing
// pass is needed. When the receiver stalls, an unsent result waits in the output
// register; a later result waits in S_DONE, holding off new requests, until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "sector_cache_lfu_controller_defines.svh"

module sector_cache_lfu_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  sclfu_pkg::sector_t  in_sector_number,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit,
  output sclfu_pkg::slot_t    out_slot,
  output logic                out_disk_read_needed,
  output logic                out_fill,
  output logic                out_evict,
  output sclfu_pkg::sector_t  out_evicted_sector,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import sclfu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  logic    enable_r, enable_nxt;
  fcnt_t   fcnt_r, fcnt_nxt;
  logic    func_r, func_nxt;
  sector_t sector_r, sector_nxt;
  logic    res_hit_r, res_hit_nxt;
  slot_t   res_slot_r, res_slot_nxt;
  logic    res_dread_r, res_dread_nxt;
  logic    res_fill_r, res_fill_nxt;
  logic    res_evict_r, res_evict_nxt;
  sector_t res_esec_r, res_esec_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_hit_r, out_hit_nxt;
  slot_t   out_slot_r, out_slot_nxt;
  logic    out_dread_r, out_dread_nxt;
  logic    out_fill_r, out_fill_nxt;
  logic    out_evict_r, out_evict_nxt;
  sector_t out_esec_r, out_esec_nxt;

  logic       scan_start;
  scan_stat_t scan_stat;
  logic       mem_rd_en;
  idx_t       mem_rd_addr;
  entry_t     mem_rd_data;
  logic       mem_wr_en;
  idx_t       mem_wr_addr;
  entry_t     mem_wr_data;
  idx_t       victim;

  sclfu_ram #(
    .DEPTH (ENTRIES),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  sclfu_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .sector  (sector_r),
    .limit   (fcnt_r),
    .rd_data (mem_rd_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .stat    (scan_stat)
  );

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    enable_nxt    = enable_r;
    fcnt_nxt      = fcnt_r;
    func_nxt      = func_r;
    sector_nxt    = sector_r;
    res_hit_nxt   = res_hit_r;
    res_slot_nxt  = res_slot_r;
    res_dread_nxt = res_dread_r;
    res_fill_nxt  = res_fill_r;
    res_evict_nxt = res_evict_r;
    res_esec_nxt  = res_esec_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    out_dread_nxt = out_dread_r;
    out_fill_nxt  = out_fill_r;
    out_evict_nxt = out_evict_r;
    out_esec_nxt  = out_esec_r;
    scan_start    = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = scan_stat.hit_idx;
    mem_wr_data   = '{tag: sector_r, count: '0};
    victim        = fcnt_r[IDX_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_we) begin
      enable_nxt = cfg_wdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          sector_nxt = in_sector_number;
          if (enable_r) begin
            scan_start = 1'b1;
            state_nxt  = S_SCAN;
          end else begin
            res_hit_nxt   = 1'b0;
            res_slot_nxt  = '0;
            res_dread_nxt = (in_func == FUNC_READ);
            res_fill_nxt  = 1'b0;
            res_evict_nxt = 1'b0;
            res_esec_nxt  = '0;
            state_nxt     = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          state_nxt = S_DONE;
          if (scan_stat.hit) begin
            res_hit_nxt   = 1'b1;
            res_slot_nxt  = slot_t'(scan_stat.hit_idx);
            res_dread_nxt = 1'b0;
            res_fill_nxt  = (func_r == FUNC_WRITE);
            res_evict_nxt = 1'b0;
            res_esec_nxt  = '0;
            // A read hit bumps the use count unless it is saturated.
            if ((func_r == FUNC_READ) && (scan_stat.hit_count != '1)) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = scan_stat.hit_idx;
              mem_wr_data = '{tag: sector_r, count: scan_stat.hit_count + count_t'(1)};
            end
          end else begin
            if (fcnt_r != FCNT_FULL) begin
              victim        = fcnt_r[IDX_W-1:0];
              fcnt_nxt      = fcnt_r + fcnt_t'(1);
              res_evict_nxt = 1'b0;
              res_esec_nxt  = '0;
            end else begin
              victim        = scan_stat.min_idx;
              res_evict_nxt = 1'b1;
              res_esec_nxt  = scan_stat.min_tag;
            end
            res_hit_nxt   = 1'b0;
            res_slot_nxt  = slot_t'(victim);
            res_dread_nxt = (func_r == FUNC_READ);
            res_fill_nxt  = 1'b1;
            mem_wr_en     = 1'b1;
            mem_wr_addr   = victim;
            mem_wr_data   = '{tag: sector_r, count: '0};
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_slot_nxt  = res_slot_r;
          out_dread_nxt = res_dread_r;
          out_fill_nxt  = res_fill_r;
          out_evict_nxt = res_evict_r;
          out_esec_nxt  = res_esec_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    sector_r    <= sector_nxt;
    res_hit_r   <= res_hit_nxt;
    res_slot_r  <= res_slot_nxt;
    res_dread_r <= res_dread_nxt;
    res_fill_r  <= res_fill_nxt;
    res_evict_r <= res_evict_nxt;
    res_esec_r  <= res_esec_nxt;
    out_hit_r   <= out_hit_nxt;
    out_slot_r  <= out_slot_nxt;
    out_dread_r <= out_dread_nxt;
    out_fill_r  <= out_fill_nxt;
    out_evict_r <= out_evict_nxt;
    out_esec_r  <= out_esec_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_slot             = out_slot_r;
  assign out_disk_read_needed = out_dread_r;
  assign out_fill             = out_fill_r;
  assign out_evict            = out_evict_r;
  assign out_evicted_sector   = out_esec_r;

  `SCL_ASSERT(a_fcnt_bound, (fcnt_r <= FCNT_FULL), "fill counter beyond capacity")
  `SCL_ASSERT(a_evict_when_full, (!(out_valid_r && out_evict_r) || (fcnt_r == FCNT_FULL)), "eviction while free entries remain")
  `SCL_ASSERT(a_hit_no_dread, (!(out_valid_r && out_hit_r && out_dread_r)), "hit also asks for a disk read")
  `SCL_ASSERT(a_fcnt_step, ((fcnt_r != $past(fcnt_r)) |-> (($past(state_r) == S_SCAN) && (fcnt_r == $past(fcnt_r) + fcnt_t'(1)))), "fill counter moved outside an allocation")

endmodule

`default_nettype wire

@@ bench/sector_cache_lfu_checker.sv @@
`timescale 1ns / 1ps

module sector_cache_lfu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_func,
  input  sclfu_pkg::sector_t in_sector_number,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_hit,
  input  sclfu_pkg::slot_t   out_slot,
  input  logic               out_disk_read_needed,
  input  logic               out_fill,
  input  logic               out_evict,
  input  sclfu_pkg::sector_t out_evicted_sector,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  import sclfu_pkg::*;

  typedef struct packed {
    logic    hit;
    slot_t   slot;
    logic    disk_read;
    logic    fill;
    logic    evict;
    sector_t evicted_sector;
  } lookup_t;

  logic    line_valid [ENTRIES];
  sector_t line_tag   [ENTRIES];
  count_t  line_count [ENTRIES];
  logic    cache_on;
  lookup_t lookup_q [$];
  int      mismatches = 0;

  assign fail_count = mismatches;

  // Updates the tag store the way the controller does and returns its answer.
  function automatic lookup_t lookup_sector(input logic func, input sector_t sector);
    lookup_t r;
    int      idx;
    int      i;
    r   = '0;
    idx = -1;
    if (!cache_on) begin
      r.disk_read = (func == FUNC_READ);
      return r;
    end
    for (i = 0; i < ENTRIES && idx < 0; i++) begin
      if (line_valid[i] && line_tag[i] == sector) idx = i;
    end
    if (idx >= 0) begin
      r.hit  = 1'b1;
      r.slot = slot_t'(idx);
      if (func == FUNC_WRITE) r.fill = 1'b1;
      else if (line_count[idx] != '1) line_count[idx] = line_count[idx] + 1'b1;
      return r;
    end
    r.disk_read = (func == FUNC_READ);
    for (i = 0; i < ENTRIES && idx < 0; i++) begin
      if (!line_valid[i]) idx = i;
    end
    if (idx < 0) begin
      // Full cache: the first entry holding the smallest count is replaced.
      idx = 0;
      for (i = 1; i < ENTRIES; i++) begin
        if (line_count[i] < line_count[idx]) idx = i;
      end
      r.evict          = 1'b1;
      r.evicted_sector = line_tag[idx];
    end
    line_valid[idx] = 1'b1;
    line_tag[idx]   = sector;
    line_count[idx] = '0;
    r.fill = 1'b1;
    r.slot = slot_t'(idx);
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    int      i;
    if (!rst_n) begin
      for (i = 0; i < ENTRIES; i++) begin
        line_valid[i] = 1'b0;
        line_count[i] = '0;
      end
      cache_on = 1'b0;
      lookup_q.delete();
      pending <= 0;
    end else begin
      // Results are checked before the request of the same edge is predicted,
      // so a result with nothing waiting cannot match a fresh expectation.
      if (out_valid && out_ready) begin
        got.hit            = out_hit;
        got.slot           = out_slot;
        got.disk_read      = out_disk_read_needed;
        got.fill           = out_fill;
        got.evict          = out_evict;
        got.evicted_sector = out_evicted_sector;
        if (lookup_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: hit=%0b slot=%0d dread=%0b ",
                     got.hit, got.slot, got.disk_read,
                     "fill=%0b evict=%0b esec=%h",
                     got.fill, got.evict, got.evicted_sector);
        end else begin
          want = lookup_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected hit=%0b slot=%0d dread=%0b fill=%0b ",
                       want.hit, want.slot, want.disk_read, want.fill,
                       "evict=%0b esec=%h, ",
                       want.evict, want.evicted_sector,
                       "got hit=%0b slot=%0d dread=%0b fill=%0b evict=%0b esec=%h",
                       got.hit, got.slot, got.disk_read, got.fill,
                       got.evict, got.evicted_sector);
          end
        end
      end
      if (cfg_we) cache_on = cfg_wdata;
      if (in_valid && in_ready) lookup_q.push_back(lookup_sector(in_func, in_sector_number));
      pending <= lookup_q.size();
    end
  end

endmodule

@@ bench/sector_cache_lfu_controller_tb.sv @@
`timescale 1ns / 1ps

module sector_cache_lfu_controller_tb;
  import sclfu_pkg::*;

  localparam int      HALF_PERIOD    = 6;
  localparam int      RESET_CYCLES   = 7;
  localparam int      WATCHDOG_LIMIT = 12000;
  localparam int      DRAIN_CYCLES   = 1100;
  localparam int      RANDOM_ROUNDS  = 6;
  localparam int      ROUND_ITEMS    = 45;
  localparam logic    CACHE_OFF      = 1'b0;
  localparam logic    CACHE_ON       = 1'b1;
  localparam sector_t SECTOR_MAX     = '1;

  logic    clk              = 1'b0;
  logic    rst_n            = 1'b0;
  logic    in_valid         = 1'b0;
  logic    in_func          = FUNC_READ;
  sector_t in_sector_number = '0;
  logic    out_ready        = 1'b0;
  logic    cfg_we           = 1'b0;
  logic    cfg_wdata        = CACHE_OFF;

  logic    in_ready;
  logic    out_valid;
  logic    out_hit;
  slot_t   out_slot;
  logic    out_disk_read_needed;
  logic    out_fill;
  logic    out_evict;
  sector_t out_evicted_sector;
  int      fail_count;
  int      pending;

  logic    enabled = CACHE_OFF;
  bit      cached [sector_t];
  sector_t known [$];
  int      burst_left   = 0;
  int      long_gap_pct = 12;
  int      idle_cycles  = 0;

  int      rx_left   = 0;
  int      rx_mode   = 0;
  int      rx_period = 4;
  int      rx_low    = 1;
  int      rx_tick   = 0;

  sector_cache_lfu_controller u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_sector_number     (in_sector_number),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_hit              (out_hit),
    .out_slot             (out_slot),
    .out_disk_read_needed (out_disk_read_needed),
    .out_fill             (out_fill),
    .out_evict            (out_evict),
    .out_evicted_sector   (out_evicted_sector),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata)
  );

  sector_cache_lfu_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_sector_number     (in_sector_number),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_hit              (out_hit),
    .out_slot             (out_slot),
    .out_disk_read_needed (out_disk_read_needed),
    .out_fill             (out_fill),
    .out_evict            (out_evict),
    .out_evicted_sector   (out_evicted_sector),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // Receiver: ready always, ready at random, or a periodic stall pattern.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_left   <= $urandom_range(40, 400);
      rx_mode   <= $urandom_range(0, 2);
      rx_period <= $urandom_range(2, 20);
      rx_low    <= $urandom_range(1, 19);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready <= ((rx_tick % rx_period) >= (rx_low % rx_period));
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sector_cache_lfu_controller_tb NOT OK");
      $finish;
    end
  end

  task automatic send_req(input logic func, input sector_t sector);
    int gap;
    in_valid         <= 1'b1;
    in_func          <= func;
    in_sector_number <= sector;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if ($urandom_range(0, 99) < long_gap_pct) gap = $urandom_range(13, 1100);
      else gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every request has had its result transaction.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_enable(input logic value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    enabled = value;
  endtask

  task automatic note_cached(input sector_t sector);
    cached[sector] = 1'b1;
    known.push_back(sector);
  endtask

  task automatic send_fresh(input logic func);
    sector_t sector;
    sector = sector_t'($urandom);
    while (cached.exists(sector)) sector = sector_t'($urandom);
    note_cached(sector);
    send_req(func, sector);
  endtask

  // Recently allocated sectors are favored so that hits stay likely.
  function automatic sector_t pick_known();
    int n;
    n = known.size();
    if (n > 128 && $urandom_range(0, 99) < 70) return known[$urandom_range(n - 128, n - 1)];
    return known[$urandom_range(0, n - 1)];
  endfunction

  initial begin
    int   i;
    int   k;
    int   pick;
    logic func;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The cache comes out of reset disabled.
    send_req(FUNC_READ, '0);
    send_req(FUNC_WRITE, SECTOR_MAX);
    send_req(FUNC_READ, SECTOR_MAX);
    send_req(FUNC_WRITE, '0);

    set_enable(CACHE_ON);
    note_cached('0);
    send_req(FUNC_READ, '0);
    send_req(FUNC_READ, '0);
    send_req(FUNC_WRITE, '0);
    note_cached(SECTOR_MAX);
    send_req(FUNC_WRITE, SECTOR_MAX);
    send_req(FUNC_READ, SECTOR_MAX);
    note_cached(28'h5555555);
    send_req(FUNC_READ, 28'h5555555);
    send_req(FUNC_WRITE, 28'h5555555);
    note_cached(28'hAAAAAAA);
    send_req(FUNC_WRITE, 28'hAAAAAAA);
    send_req(FUNC_READ, 28'hAAAAAAA);

    // Cached sectors must not hit while the cache is off.
    set_enable(CACHE_OFF);
    send_req(FUNC_READ, '0);
    send_req(FUNC_WRITE, SECTOR_MAX);
    set_enable(CACHE_ON);
    send_req(FUNC_READ, '0);

    // Mixed traffic of hits and allocations, with the cache switched off at times.
    for (k = 0; k < RANDOM_ROUNDS; k++) begin
      set_enable((k == 1 || k == 4) ? CACHE_OFF : CACHE_ON);
      for (i = 0; i < ROUND_ITEMS; i++) begin
        func = logic'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 45) send_req(func, pick_known());
        else if (pick < 90 && enabled == CACHE_ON) send_fresh(func);
        else send_req(func, sector_t'($urandom));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sector_cache_lfu_controller_tb OK");
    end else begin
      $display("sector_cache_lfu_controller_tb NOT OK");
    end
    $finish;
  end

endmodule
